>>> sv/dlog_pkg.sv
// dlog_pkg: shared types and constants for the dedup error log table
// request and response words, mode, status and sequencer state codes
// no dependencies

package dlog_pkg;

	localparam int CAPACITY = 16;
	localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int FILL_W   = 5;
	localparam int SLOT_W   = 8;
	localparam int DESC_W   = 32;
	localparam int FILE_W   = 32;
	localparam int LINE_W   = 16;
	localparam int ENTRY_W  = DESC_W + FILE_W + LINE_W;

	typedef enum logic [1:0] {
		MODE_ADD    = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_CLEAR  = 2'd2,
		MODE_READ   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_DUP     = 2'd1,
		ST_EVICT   = 2'd2,
		ST_BAD_IDX = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_WRITE,
		S_READ,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic [1:0]        mode;
		logic [DESC_W-1:0] desc_id;
		logic [FILE_W-1:0] file_id;
		logic [LINE_W-1:0] line_num;
		logic [SLOT_W-1:0] slot;
	} req_word_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [FILL_W-1:0] fill;
		logic [DESC_W-1:0] out_desc;
		logic [FILE_W-1:0] out_file;
		logic [LINE_W-1:0] out_line;
	} rsp_word_t;

	typedef struct packed {
		logic [DESC_W-1:0] desc;
		logic [FILE_W-1:0] file;
		logic [LINE_W-1:0] line;
	} entry_t;

endpackage

>>> sv/dlog_ram.sv
// dlog_ram: generic single write port, single read port ram
// read data is registered; no dependencies

module dlog_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> sv/dedup_error_log_table.sv
// dedup_error_log_table: ordered error log of up to CAPACITY records with duplicate removal
// uses dlog_pkg for types and constants and dlog_ram for the entry store

// Each request word gives exactly one response word. The entries sit in one ram
// with a single read and a single write port, and one comparator walks it a word
// per cycle. An add scans all held entries; a new record is then written, or,
// when the log is full, written after a shift of the whole store. A remove shifts
// the entries above the slot, a read fetches one slot and a clear empties the
// log. The response sits in an output register, so the next request is taken
// while it waits.

module dedup_error_log_table (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  dlog_pkg::req_word_t  req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output dlog_pkg::rsp_word_t  rsp
);

	localparam int AW = dlog_pkg::ADDR_W;
	localparam int CW = dlog_pkg::CNT_W;

	dlog_pkg::state_t  state_q, state_d;
	dlog_pkg::mode_t   op_q;
	dlog_pkg::status_t status_q;
	dlog_pkg::entry_t  key_q;
	dlog_pkg::rsp_word_t rsp_q;
	logic [AW-1:0]     slot_q;
	logic [AW-1:0]     dst_s1;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     idx_q;
	logic [CW-1:0]     idx_plus;
	logic              pend_q;
	logic              dup_q;
	logic              full_q;
	logic              rsp_valid_q;
	logic              accept;
	logic              bad_idx;
	logic              scan_done;
	logic              shift_done;
	logic              rsp_load;
	logic              hit;

	logic              ram_we;
	logic              ram_re;
	logic [AW-1:0]     ram_waddr;
	logic [AW-1:0]     ram_raddr;
	dlog_pkg::entry_t  ram_wdata;
	dlog_pkg::entry_t  ram_rdata;

	dlog_ram #(
		.WIDTH(dlog_pkg::ENTRY_W),
		.DEPTH(dlog_pkg::CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign req_stall  = (state_q != dlog_pkg::S_IDLE);
	assign accept     = req_valid && !req_stall;
	assign bad_idx    = (32'(req.slot) >= 32'(count_q));
	assign idx_plus   = idx_q + 1'b1;
	assign scan_done  = !pend_q && (idx_q >= count_q);
	assign shift_done = !pend_q && (idx_plus >= count_q);
	assign rsp_load   = !rsp_valid_q || !rsp_stall;
	assign hit        = pend_q && (ram_rdata == key_q);
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dlog_pkg::S_IDLE: begin
				if (accept) begin
					unique case (dlog_pkg::mode_t'(req.mode))
						dlog_pkg::MODE_ADD:    state_d = dlog_pkg::S_SCAN;
						dlog_pkg::MODE_REMOVE: state_d = bad_idx ? dlog_pkg::S_FINISH
						                                         : dlog_pkg::S_SHIFT;
						dlog_pkg::MODE_CLEAR:  state_d = dlog_pkg::S_FINISH;
						dlog_pkg::MODE_READ:   state_d = bad_idx ? dlog_pkg::S_FINISH
						                                         : dlog_pkg::S_READ;
						default:               state_d = dlog_pkg::S_IDLE;
					endcase
				end
			end
			dlog_pkg::S_SCAN: begin
				if (scan_done) begin
					priority if (dup_q) begin
						state_d = dlog_pkg::S_FINISH;
					end else if (full_q) begin
						state_d = dlog_pkg::S_SHIFT;
					end else begin
						state_d = dlog_pkg::S_WRITE;
					end
				end
			end
			dlog_pkg::S_SHIFT: begin
				if (shift_done) begin
					state_d = (op_q == dlog_pkg::MODE_ADD) ? dlog_pkg::S_WRITE
					                                       : dlog_pkg::S_FINISH;
				end
			end
			dlog_pkg::S_WRITE:  state_d = dlog_pkg::S_FINISH;
			dlog_pkg::S_READ:   state_d = dlog_pkg::S_FINISH;
			dlog_pkg::S_FINISH: begin
				if (rsp_load) begin
					state_d = dlog_pkg::S_IDLE;
				end
			end
			default: state_d = dlog_pkg::S_IDLE;
		endcase
	end

	// ram control
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = idx_q[AW-1:0];
		ram_we    = 1'b0;
		ram_waddr = dst_s1;
		ram_wdata = ram_rdata;
		unique case (state_q)
			dlog_pkg::S_SCAN: begin
				ram_re    = (idx_q < count_q);
				ram_raddr = idx_q[AW-1:0];
			end
			dlog_pkg::S_SHIFT: begin
				ram_re    = (idx_plus < count_q);
				ram_raddr = idx_plus[AW-1:0];
				ram_we    = pend_q;
				ram_waddr = dst_s1;
				ram_wdata = ram_rdata;
			end
			dlog_pkg::S_WRITE: begin
				ram_we    = 1'b1;
				ram_waddr = full_q ? AW'(dlog_pkg::CAPACITY - 1) : count_q[AW-1:0];
				ram_wdata = key_q;
			end
			dlog_pkg::S_READ: begin
				ram_re    = 1'b1;
				ram_raddr = slot_q;
			end
			default: begin
				ram_re = 1'b0;
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dlog_pkg::S_IDLE;
			op_q        <= dlog_pkg::MODE_ADD;
			status_q    <= dlog_pkg::ST_DONE;
			count_q     <= '0;
			idx_q       <= '0;
			dst_s1      <= '0;
			pend_q      <= 1'b0;
			dup_q       <= 1'b0;
			full_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == dlog_pkg::S_FINISH && rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				dlog_pkg::S_IDLE: begin
					if (accept) begin
						op_q   <= dlog_pkg::mode_t'(req.mode);
						pend_q <= 1'b0;
						dup_q  <= 1'b0;
						full_q <= (count_q == CW'(dlog_pkg::CAPACITY));
						idx_q  <= (req.mode == dlog_pkg::MODE_REMOVE) ? CW'(req.slot) : '0;
						if ((req.mode == dlog_pkg::MODE_REMOVE ||
						     req.mode == dlog_pkg::MODE_READ) && bad_idx) begin
							status_q <= dlog_pkg::ST_BAD_IDX;
						end else begin
							status_q <= dlog_pkg::ST_DONE;
						end
						if (req.mode == dlog_pkg::MODE_CLEAR) begin
							count_q <= '0;
						end
					end
				end
				dlog_pkg::S_SCAN: begin
					if (hit) begin
						dup_q <= 1'b1;
					end
					if (idx_q < count_q) begin
						idx_q  <= idx_plus;
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
					end
					if (scan_done) begin
						idx_q <= '0;
						priority if (dup_q) begin
							status_q <= dlog_pkg::ST_DUP;
						end else if (full_q) begin
							status_q <= dlog_pkg::ST_EVICT;
						end else begin
							status_q <= dlog_pkg::ST_DONE;
						end
					end
				end
				dlog_pkg::S_SHIFT: begin
					if (idx_plus < count_q) begin
						idx_q  <= idx_plus;
						dst_s1 <= idx_q[AW-1:0];
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
					end
					if (shift_done && op_q == dlog_pkg::MODE_REMOVE) begin
						count_q <= count_q - 1'b1;
					end
				end
				dlog_pkg::S_WRITE: begin
					if (!full_q) begin
						count_q <= count_q + 1'b1;
					end
				end
				default: begin
					pend_q <= 1'b0;
				end
			endcase
		end
	end

	// response word and captured request fields
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q.desc <= req.desc_id;
			key_q.file <= req.file_id;
			key_q.line <= req.line_num;
			slot_q     <= req.slot[AW-1:0];
		end
		if (state_q == dlog_pkg::S_FINISH && rsp_load) begin
			rsp_q.status <= status_q;
			rsp_q.fill   <= dlog_pkg::FILL_W'(count_q);
			if (op_q == dlog_pkg::MODE_READ && status_q == dlog_pkg::ST_DONE) begin
				rsp_q.out_desc <= ram_rdata.desc;
				rsp_q.out_file <= ram_rdata.file;
				rsp_q.out_line <= ram_rdata.line;
			end else begin
				rsp_q.out_desc <= '0;
				rsp_q.out_file <= '0;
				rsp_q.out_line <= '0;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(dlog_pkg::CAPACITY))
		else $error("entry count above capacity");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != dlog_pkg::S_IDLE)
		else $error("accepted word not processed");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.mode == dlog_pkg::MODE_CLEAR |=> count_q == '0)
		else $error("clear left entries");

	a_shift_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && state_q == dlog_pkg::S_SHIFT |-> CW'(ram_waddr) < count_q)
		else $error("shift write beyond held entries");

	a_rsp_only_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == dlog_pkg::S_FINISH)
		else $error("response raised outside finish");

endmodule

>>> sim/tb_dedup_error_log_table.sv
// tb_dedup_error_log_table: self-checking bench for the dedup error log table
// a scoreboard class predicts every response word; plain tasks drive requests
// depends on dlog_pkg and dedup_error_log_table
`timescale 1ns / 1ps

class log_scoreboard;
	dlog_pkg::entry_t    held[$];
	dlog_pkg::rsp_word_t awaiting_rsp[$];
	int                  errors = 0;

	function void note_request(dlog_pkg::req_word_t w);
		dlog_pkg::rsp_word_t r;
		dlog_pkg::entry_t    e;
		bit                  dup;
		r = '0;
		e = '{desc: w.desc_id, file: w.file_id, line: w.line_num};
		dup = 1'b0;
		case (dlog_pkg::mode_t'(w.mode))
		dlog_pkg::MODE_ADD: begin
			foreach (held[i])
				if (held[i] == e)
					dup = 1'b1;
			if (dup) begin
				r.status = dlog_pkg::ST_DUP;
			end else begin
				if (held.size() >= dlog_pkg::CAPACITY) begin
					held.delete(0);
					r.status = dlog_pkg::ST_EVICT;
				end
				held.push_back(e);
			end
		end
		dlog_pkg::MODE_REMOVE: begin
			if (w.slot >= held.size())
				r.status = dlog_pkg::ST_BAD_IDX;
			else
				held.delete(w.slot);
		end
		dlog_pkg::MODE_CLEAR: begin
			held.delete();
		end
		default: begin
			if (w.slot >= held.size()) begin
				r.status = dlog_pkg::ST_BAD_IDX;
			end else begin
				r.out_desc = held[w.slot].desc;
				r.out_file = held[w.slot].file;
				r.out_line = held[w.slot].line;
			end
		end
		endcase
		r.fill = dlog_pkg::FILL_W'(held.size());
		awaiting_rsp.push_back(r);
	endfunction

	function void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endfunction

	function void check_response(dlog_pkg::rsp_word_t got);
		dlog_pkg::rsp_word_t want;
		if (awaiting_rsp.size() == 0) begin
			$error("response word 0x%0h with nothing expected", got);
			errors++;
			return;
		end
		want = awaiting_rsp.pop_front();
		compare_field("status", 32'(want.status), 32'(got.status));
		compare_field("fill", 32'(want.fill), 32'(got.fill));
		compare_field("out_desc", want.out_desc, got.out_desc);
		compare_field("out_file", want.out_file, got.out_file);
		compare_field("out_line", 32'(want.out_line), 32'(got.out_line));
	endfunction
endclass

module tb_dedup_error_log_table;
	import dlog_pkg::*;

	localparam int RANDOM_WORDS = 1400;
	localparam int POOL_SIZE    = 20;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_word_t req       = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_word_t rsp;

	log_scoreboard sb = new();
	entry_t        pool[POOL_SIZE];
	int unsigned   stall_cycle = 0;

	dedup_error_log_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && req_valid && !req_stall)
			sb.note_request(req);
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_response(rsp);
	end

	// receiver: free-running, light, heavy and periodic stall phases
	always @(posedge clk) begin
		stall_cycle <= stall_cycle + 1;
		case ((stall_cycle / 256) % 4)
		0: rsp_stall <= 1'b0;
		1: rsp_stall <= ($urandom_range(0, 3) == 0);
		2: rsp_stall <= ($urandom_range(0, 3) != 0);
		default: rsp_stall <= ((stall_cycle % 16) < 9);
		endcase
	end

	task automatic send_word(input req_word_t w);
		req <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic pause(input int unsigned n);
		req_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic hold_until_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (sb.awaiting_rsp.size() != 0);
	endtask

	function automatic req_word_t mk(mode_t m, logic [DESC_W-1:0] d, logic [FILE_W-1:0] f,
			logic [LINE_W-1:0] l, logic [SLOT_W-1:0] s);
		req_word_t w;
		w.mode = m;
		w.desc_id = d;
		w.file_id = f;
		w.line_num = l;
		w.slot = s;
		return w;
	endfunction

	function automatic entry_t fresh_entry();
		entry_t e;
		e.desc = $urandom();
		e.file = $urandom();
		e.line = LINE_W'($urandom());
		return e;
	endfunction

	function automatic req_word_t random_word();
		req_word_t   w;
		entry_t      e;
		int unsigned pick;
		w.desc_id = $urandom();
		w.file_id = $urandom();
		w.line_num = LINE_W'($urandom());
		w.slot = ($urandom_range(0, 99) < 85) ? SLOT_W'($urandom_range(0, CAPACITY + 1))
			: SLOT_W'($urandom_range(0, 255));
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			w.mode = MODE_ADD;
			e = pool[$urandom_range(0, POOL_SIZE - 1)];
			case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: ;
			6: begin
				case ($urandom_range(0, 2))
				0: e.desc[$urandom_range(0, DESC_W - 1)] ^= 1'b1;
				1: e.file[$urandom_range(0, FILE_W - 1)] ^= 1'b1;
				default: e.line[$urandom_range(0, LINE_W - 1)] ^= 1'b1;
				endcase
			end
			7: begin
				pool[$urandom_range(0, POOL_SIZE - 1)] = fresh_entry();
				e = fresh_entry();
			end
			default: e = fresh_entry();
			endcase
			w.desc_id = e.desc;
			w.file_id = e.file;
			w.line_num = e.line;
		end else if (pick < 70) begin
			w.mode = MODE_REMOVE;
		end else if (pick < 72) begin
			w.mode = MODE_CLEAR;
		end else begin
			w.mode = MODE_READ;
		end
		return w;
	endfunction

	initial begin
		int unsigned sent;
		int unsigned burst;
		foreach (pool[i])
			pool[i] = fresh_entry();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty log corner cases
		send_word(mk(MODE_CLEAR, '0, '0, '0, '0));
		send_word(mk(MODE_READ, '0, '0, '0, '0));
		send_word(mk(MODE_REMOVE, '0, '0, '0, '1));
		// field extremes, duplicate and near duplicates
		send_word(mk(MODE_ADD, '1, '1, '1, '1));
		send_word(mk(MODE_ADD, '0, '0, '0, '0));
		send_word(mk(MODE_ADD, '1, '1, '1, '0));
		send_word(mk(MODE_ADD, '1, '1, 16'hfffe, '0));
		send_word(mk(MODE_ADD, '1, 32'hffff_fffe, '1, '0));
		send_word(mk(MODE_ADD, 32'h7fff_ffff, '1, '1, '0));
		// fill up, then evict the oldest
		for (int i = 0; i < CAPACITY - 5; i++)
			send_word(mk(MODE_ADD, 32'h1000 + i, 32'h2000 + i, LINE_W'(i), '0));
		send_word(mk(MODE_ADD, 32'hdead_beef, 32'hcafe_f00d, 16'h1234, '0));
		send_word(mk(MODE_READ, '0, '0, '0, SLOT_W'(CAPACITY - 1)));
		send_word(mk(MODE_READ, '0, '0, '0, SLOT_W'(CAPACITY)));
		send_word(mk(MODE_REMOVE, '0, '0, '0, '0));
		send_word(mk(MODE_REMOVE, '0, '0, '0, SLOT_W'(CAPACITY - 2)));
		send_word(mk(MODE_CLEAR, '0, '0, '0, '0));
		hold_until_drained();

		sent = 0;
		while (sent < RANDOM_WORDS) begin
			burst = $urandom_range(1, 24);
			for (int k = 0; k < burst && sent < RANDOM_WORDS; k++) begin
				send_word(random_word());
				sent++;
			end
			case ($urandom_range(0, 9))
			0: hold_until_drained();
			1, 2, 3: ;
			default: pause($urandom_range(1, 12));
			endcase
		end

		hold_until_drained();
		repeat (2 * CAPACITY + 10) @(posedge clk);
		if (sb.errors == 0 && sb.awaiting_rsp.size() == 0)
			$display("[dedup_error_log_table] OK");
		else
			$display("[dedup_error_log_table] ERROR");
		$finish;
	end

	initial begin
		#8ms;
		$display("[dedup_error_log_table] ERROR");
		$finish;
	end

endmodule

>>> files.f
sv/dlog_pkg.sv
sv/dlog_ram.sv
sv/dedup_error_log_table.sv
sim/tb_dedup_error_log_table.sv
